/* src/frame_descriptor_parser_macros.svh */
// assertion macros for the frame descriptor parser
`ifndef FRAME_DESCRIPTOR_PARSER_MACROS_SVH
`define FRAME_DESCRIPTOR_PARSER_MACROS_SVH
`ifndef SYNTHESIS
`define FDP_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);
`define FDP_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);
`else
`define FDP_ASSERT_ALWAYS(label, cond, msg)
`define FDP_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

/* src/fdp_pkg.sv */
// shared types and constants of the frame descriptor parser
package fdp_pkg;

   // dependency limit and counter width
   localparam int unsigned MAX_DEPS    = 8;
   localparam int unsigned DEP_COUNT_W = 4;
   localparam int unsigned DIFF_W      = 14;

   // result queue sizing
   localparam int unsigned FIFO_DEPTH   = 4;
   localparam int unsigned FIFO_PTR_W   = 2;
   localparam int unsigned FIFO_COUNT_W = 3;

   // summary status codes
   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_TRUNCATED = 3'd1;
   localparam logic [2:0] STATUS_EXTRA     = 3'd2;
   localparam logic [2:0] STATUS_ZERO_DIFF = 3'd3;
   localparam logic [2:0] STATUS_TOO_MANY  = 3'd4;

   // result kinds
   localparam logic KIND_DEPENDENCY = 1'b0;
   localparam logic KIND_SUMMARY    = 1'b1;

   // one result item
   typedef struct packed {
      logic                   item_kind;
      logic [2:0]             status;
      logic                   first_in_subframe;
      logic                   last_in_subframe;
      logic [2:0]             temporal_id;
      logic [7:0]             spatial_mask;
      logic [15:0]            frame_number;
      logic [15:0]            frame_width;
      logic [15:0]            frame_height;
      logic [DIFF_W-1:0]      id_difference;
      logic [DEP_COUNT_W-1:0] dependency_total;
      logic                   end_of_run;
   } result_item_type;

endpackage

/* src/frame_descriptor_parser.sv */
// frame descriptor parser: byte-wise payload parse and result queue
// A result enters the result queue when its byte is accepted; rsp offers the queue head.
// Throughput: one payload byte per cycle while the four-entry result queue has
// room for two results; each result leaves in one rsp transfer, so a byte that
// gives a dependency and the summary needs two output transfers.
// Reset: synchronous, clears the parse state and empties the result queue.
`include "frame_descriptor_parser_macros.svh"
module frame_descriptor_parser (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_payload_byte,
   input  logic                                 req_final_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_item_kind,
   output logic [2:0]                           rsp_status,
   output logic                                 rsp_first_in_subframe,
   output logic                                 rsp_last_in_subframe,
   output logic [2:0]                           rsp_temporal_id,
   output logic [7:0]                           rsp_spatial_mask,
   output logic [15:0]                          rsp_frame_number,
   output logic [15:0]                          rsp_frame_width,
   output logic [15:0]                          rsp_frame_height,
   output logic [fdp_pkg::DIFF_W-1:0]           rsp_id_difference,
   output logic [fdp_pkg::DEP_COUNT_W-1:0]      rsp_dependency_total,
   output logic                                 rsp_end_of_run
);
   import fdp_pkg::*;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_SPATIAL,
      PH_FID_LO,
      PH_FID_HI,
      PH_RES,
      PH_DEP,
      PH_DEP_EXT,
      PH_IGNORE
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic                   begin_ff, begin_in;
   logic                   end_ff, end_in;
   logic [2:0]             temporal_ff, temporal_in;
   logic [7:0]             spatial_ff, spatial_in;
   logic [15:0]            fid_ff, fid_in;
   logic [15:0]            width_ff, width_in;
   logic [15:0]            height_ff, height_in;
   logic [1:0]             res_idx_ff, res_idx_in;
   logic [5:0]             low_diff_ff, low_diff_in;
   logic                   more_ff, more_in;
   logic [DEP_COUNT_W-1:0] deps_ff, deps_in;
   logic [2:0]             error_ff, error_in;

   logic                   in_xfer;
   logic                   last_xfer;
   logic                   out_xfer;
   logic                   cand_valid;
   logic [DIFF_W-1:0]      cand_diff;
   logic                   dep_emit;
   logic [2:0]             sum_status;
   logic                   show_size;
   logic                   truncated;
   result_item_type        dep_item;
   result_item_type        sum_item;
   result_item_type        slot0;
   result_item_type        slot1;
   logic [1:0]             push_count;

   result_item_type         queue_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_COUNT_W-1:0] count_ff, count_in;
   result_item_type         head;

   // handshake
   assign in_xfer   = req_valid && !req_stall;
   assign last_xfer = in_xfer && req_final_byte;
   assign out_xfer  = rsp_valid && !rsp_stall;
   assign req_stall = count_ff > FIFO_COUNT_W'(FIFO_DEPTH - 2);
   assign rsp_valid = count_ff != '0;

   // next parse state for the presented byte
   always_comb begin
      phase_in    = phase_ff;
      begin_in    = begin_ff;
      end_in      = end_ff;
      temporal_in = temporal_ff;
      spatial_in  = spatial_ff;
      fid_in      = fid_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      res_idx_in  = res_idx_ff;
      low_diff_in = low_diff_ff;
      more_in     = more_ff;
      deps_in     = deps_ff;
      error_in    = error_ff;
      cand_valid  = 1'b0;
      cand_diff   = '0;
      dep_emit    = 1'b0;
      unique case (phase_ff)
         PH_HEADER: begin
            begin_in = req_payload_byte[7];
            end_in   = req_payload_byte[6];
            if (!req_payload_byte[7]) begin
               if (!req_final_byte) begin
                  error_in = STATUS_EXTRA;
               end
               phase_in = PH_IGNORE;
            end else begin
               temporal_in = req_payload_byte[2:0];
               more_in     = req_payload_byte[3];
               phase_in    = PH_SPATIAL;
            end
         end
         PH_SPATIAL: begin
            spatial_in = req_payload_byte;
            phase_in   = PH_FID_LO;
         end
         PH_FID_LO: begin
            fid_in   = {8'd0, req_payload_byte};
            phase_in = PH_FID_HI;
         end
         PH_FID_HI: begin
            fid_in     = {req_payload_byte, fid_ff[7:0]};
            phase_in   = more_ff ? PH_DEP : PH_RES;
            res_idx_in = 2'd0;
         end
         PH_RES: begin
            case (res_idx_ff)
               2'd0: width_in = {req_payload_byte, 8'd0};
               2'd1: width_in = {width_ff[15:8], req_payload_byte};
               2'd2: height_in = {req_payload_byte, 8'd0};
               default: height_in = {height_ff[15:8], req_payload_byte};
            endcase
            if (res_idx_ff == 2'd3) begin
               phase_in = PH_IGNORE;
            end
            res_idx_in = res_idx_ff + 2'd1;
         end
         PH_DEP: begin
            more_in = req_payload_byte[0];
            if (req_payload_byte[1]) begin
               low_diff_in = req_payload_byte[7:2];
               phase_in    = PH_DEP_EXT;
            end else begin
               cand_valid = 1'b1;
               cand_diff  = {8'd0, req_payload_byte[7:2]};
            end
         end
         PH_DEP_EXT: begin
            cand_valid = 1'b1;
            cand_diff  = {req_payload_byte, low_diff_ff};
         end
         PH_IGNORE: begin
            phase_in = PH_IGNORE;
         end
      endcase

      // dependency check: limit first, then zero difference
      if (cand_valid) begin
         if (deps_ff >= DEP_COUNT_W'(MAX_DEPS)) begin
            error_in = STATUS_TOO_MANY;
            phase_in = PH_IGNORE;
         end else if (cand_diff == '0) begin
            error_in = STATUS_ZERO_DIFF;
            phase_in = PH_IGNORE;
         end else begin
            deps_in  = deps_ff + DEP_COUNT_W'(1);
            dep_emit = 1'b1;
            phase_in = more_in ? PH_DEP : PH_IGNORE;
         end
      end
   end

   // summary status and reported size
   assign truncated = phase_in == PH_SPATIAL || phase_in == PH_FID_LO ||
                      phase_in == PH_FID_HI || phase_in == PH_DEP ||
                      phase_in == PH_DEP_EXT;
   assign sum_status = (error_in == STATUS_OK && truncated) ? STATUS_TRUNCATED : error_in;
   assign show_size  = error_in == STATUS_OK && phase_in == PH_IGNORE && deps_in == '0;

   // result items built from the updated state
   always_comb begin
      dep_item.item_kind         = KIND_DEPENDENCY;
      dep_item.status            = STATUS_OK;
      dep_item.first_in_subframe = begin_in;
      dep_item.last_in_subframe  = end_in;
      dep_item.temporal_id       = temporal_in;
      dep_item.spatial_mask      = spatial_in;
      dep_item.frame_number      = fid_in;
      dep_item.frame_width       = 16'd0;
      dep_item.frame_height      = 16'd0;
      dep_item.id_difference     = cand_diff;
      dep_item.dependency_total  = deps_in;
      dep_item.end_of_run        = 1'b0;

      sum_item                   = dep_item;
      sum_item.item_kind         = KIND_SUMMARY;
      sum_item.status            = sum_status;
      sum_item.frame_width       = show_size ? width_in : 16'd0;
      sum_item.frame_height      = show_size ? height_in : 16'd0;
      sum_item.id_difference     = '0;
      sum_item.end_of_run        = 1'b1;
   end

   // queue slots in model order: dependency, then summary
   assign slot0      = dep_emit ? dep_item : sum_item;
   assign slot1      = sum_item;
   assign push_count = {1'b0, in_xfer && dep_emit} + {1'b0, last_xfer};

   // queue pointers and fill level
   assign wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(push_count);
   assign rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(out_xfer);
   assign count_in  = count_ff + FIFO_COUNT_W'(push_count) - FIFO_COUNT_W'(out_xfer);

   // parse state and queue control
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         begin_ff    <= 1'b0;
         end_ff      <= 1'b0;
         temporal_ff <= '0;
         spatial_ff  <= '0;
         fid_ff      <= '0;
         width_ff    <= '0;
         height_ff   <= '0;
         res_idx_ff  <= '0;
         low_diff_ff <= '0;
         more_ff     <= 1'b0;
         deps_ff     <= '0;
         error_ff    <= STATUS_OK;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         if (in_xfer) begin
            if (req_final_byte) begin
               phase_ff    <= PH_HEADER;
               begin_ff    <= 1'b0;
               end_ff      <= 1'b0;
               temporal_ff <= '0;
               spatial_ff  <= '0;
               fid_ff      <= '0;
               width_ff    <= '0;
               height_ff   <= '0;
               res_idx_ff  <= '0;
               low_diff_ff <= '0;
               more_ff     <= 1'b0;
               deps_ff     <= '0;
               error_ff    <= STATUS_OK;
            end else begin
               phase_ff    <= phase_in;
               begin_ff    <= begin_in;
               end_ff      <= end_in;
               temporal_ff <= temporal_in;
               spatial_ff  <= spatial_in;
               fid_ff      <= fid_in;
               width_ff    <= width_in;
               height_ff   <= height_in;
               res_idx_ff  <= res_idx_in;
               low_diff_ff <= low_diff_in;
               more_ff     <= more_in;
               deps_ff     <= deps_in;
               error_ff    <= error_in;
            end
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         queue_ff[wr_ptr_ff] <= slot0;
      end
      if (push_count == 2'd2) begin
         queue_ff[wr_ptr_ff + FIFO_PTR_W'(1)] <= slot1;
      end
   end

   // head of queue drives the result channel
   assign head                  = queue_ff[rd_ptr_ff];
   assign rsp_item_kind         = head.item_kind;
   assign rsp_status            = head.status;
   assign rsp_first_in_subframe = head.first_in_subframe;
   assign rsp_last_in_subframe  = head.last_in_subframe;
   assign rsp_temporal_id       = head.temporal_id;
   assign rsp_spatial_mask      = head.spatial_mask;
   assign rsp_frame_number      = head.frame_number;
   assign rsp_frame_width       = head.frame_width;
   assign rsp_frame_height      = head.frame_height;
   assign rsp_id_difference     = head.id_difference;
   assign rsp_dependency_total  = head.dependency_total;
   assign rsp_end_of_run        = head.end_of_run;

   // checks
   `FDP_ASSERT_ALWAYS(a_queue_bound, count_ff <= FIFO_COUNT_W'(FIFO_DEPTH), "queue overflow")
   `FDP_ASSERT_ALWAYS(a_dep_bound, deps_ff <= DEP_COUNT_W'(MAX_DEPS), "too many dependencies")
   `FDP_ASSERT_NEXT(a_final_resets, last_xfer, phase_ff == PH_HEADER && deps_ff == '0, "no reset")
   `FDP_ASSERT_NEXT(a_summary_queued, last_xfer, rsp_valid, "no summary queued")

endmodule

/* bench/testbench.sv */
// self-checking testbench for the frame descriptor parser
module testbench;
   import fdp_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int TOTAL_BYTES = 1100;

   // header and dependency byte fields
   localparam logic [7:0] FLAG_BEGIN   = 8'h80;
   localparam logic [7:0] FLAG_END     = 8'h40;
   localparam logic [7:0] FLAG_CHAIN   = 8'h08;
   localparam logic [7:0] LAYER_MASK   = 8'h07;
   localparam logic [7:0] DEP_MORE     = 8'h01;
   localparam logic [7:0] DEP_EXTENDED = 8'h02;

   typedef enum logic [2:0] {
      PHASE_HEADER, PHASE_SPATIAL, PHASE_FRAME_LO, PHASE_FRAME_HI,
      PHASE_SIZE, PHASE_CHAIN, PHASE_CHAIN_EXT, PHASE_SKIP
   } parse_phase_type;

   typedef logic [7:0] byte_list_type[$];

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [7:0] req_payload_byte = 8'h00;
   logic req_final_byte = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_item_kind;
   logic [2:0] rsp_status;
   logic rsp_first_in_subframe;
   logic rsp_last_in_subframe;
   logic [2:0] rsp_temporal_id;
   logic [7:0] rsp_spatial_mask;
   logic [15:0] rsp_frame_number;
   logic [15:0] rsp_frame_width;
   logic [15:0] rsp_frame_height;
   logic [DIFF_W-1:0] rsp_id_difference;
   logic [DEP_COUNT_W-1:0] rsp_dependency_total;
   logic rsp_end_of_run;

   // descriptor state of the predictor
   parse_phase_type phase;
   logic begin_seen;
   logic end_seen;
   logic [2:0] layer_t;
   logic [7:0] layer_s;
   logic [15:0] frame_num;
   logic [15:0] size_w;
   logic [15:0] size_h;
   logic [1:0] size_index;
   logic [5:0] diff_low;
   logic more_flag;
   logic [DEP_COUNT_W-1:0] dep_count;
   logic [2:0] error_status;

   result_item_type expected_results[$];
   int max_gap = 7;
   int max_stall = 7;
   int stall_left = 0;
   int failures = 0;
   int cycle_count = 0;
   int byte_count = 0;
   int payload_count = 0;
   int dependency_count = 0;
   int summary_count = 0;

   frame_descriptor_parser dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload_byte(req_payload_byte),
      .req_final_byte(req_final_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item_kind(rsp_item_kind),
      .rsp_status(rsp_status),
      .rsp_first_in_subframe(rsp_first_in_subframe),
      .rsp_last_in_subframe(rsp_last_in_subframe),
      .rsp_temporal_id(rsp_temporal_id),
      .rsp_spatial_mask(rsp_spatial_mask),
      .rsp_frame_number(rsp_frame_number),
      .rsp_frame_width(rsp_frame_width),
      .rsp_frame_height(rsp_frame_height),
      .rsp_id_difference(rsp_id_difference),
      .rsp_dependency_total(rsp_dependency_total),
      .rsp_end_of_run(rsp_end_of_run)
   );

   always #10 clock = ~clock;

   // descriptor state back to the start of a payload
   function automatic void clear_descriptor();
      phase = PHASE_HEADER;
      begin_seen = 1'b0;
      end_seen = 1'b0;
      layer_t = '0;
      layer_s = '0;
      frame_num = '0;
      size_w = '0;
      size_h = '0;
      size_index = '0;
      diff_low = '0;
      more_flag = 1'b0;
      dep_count = '0;
      error_status = STATUS_OK;
   endfunction

   function automatic result_item_type make_result(logic kind, logic [2:0] status,
                                                   logic [15:0] w, logic [15:0] h,
                                                   logic [DIFF_W-1:0] diff);
      result_item_type r;
      r.item_kind = kind;
      r.status = status;
      r.first_in_subframe = begin_seen;
      r.last_in_subframe = end_seen;
      r.temporal_id = layer_t;
      r.spatial_mask = layer_s;
      r.frame_number = frame_num;
      r.frame_width = w;
      r.frame_height = h;
      r.id_difference = diff;
      r.dependency_total = dep_count;
      r.end_of_run = (kind == KIND_SUMMARY);
      return r;
   endfunction

   // limit is checked before the zero test; an accepted difference is a result
   function automatic void finish_dependency(logic [DIFF_W-1:0] diff);
      if (dep_count >= MAX_DEPS) begin
         error_status = STATUS_TOO_MANY;
         phase = PHASE_SKIP;
      end else if (diff == 0) begin
         error_status = STATUS_ZERO_DIFF;
         phase = PHASE_SKIP;
      end else begin
         dep_count++;
         expected_results.push_back(make_result(KIND_DEPENDENCY, STATUS_OK, '0, '0, diff));
         phase = more_flag ? PHASE_CHAIN : PHASE_SKIP;
      end
   endfunction

   // advance the parse by one accepted byte and queue what it produces
   function automatic void parse_byte(logic [7:0] value, logic fin);
      logic [2:0] status;
      logic [15:0] w;
      logic [15:0] h;
      w = '0;
      h = '0;
      case (phase)
         PHASE_HEADER: begin
            begin_seen = (value & FLAG_BEGIN) != 0;
            end_seen = (value & FLAG_END) != 0;
            if (!begin_seen) begin
               if (!fin)
                  error_status = STATUS_EXTRA;
               phase = PHASE_SKIP;
            end else begin
               layer_t = 3'(value & LAYER_MASK);
               more_flag = (value & FLAG_CHAIN) != 0;
               phase = PHASE_SPATIAL;
            end
         end
         PHASE_SPATIAL: begin
            layer_s = value;
            phase = PHASE_FRAME_LO;
         end
         PHASE_FRAME_LO: begin
            frame_num = {8'h00, value};
            phase = PHASE_FRAME_HI;
         end
         PHASE_FRAME_HI: begin
            frame_num[15:8] = value;
            phase = more_flag ? PHASE_CHAIN : PHASE_SIZE;
            size_index = '0;
         end
         PHASE_SIZE: begin
            case (size_index)
               2'd0: size_w = {value, 8'h00};
               2'd1: size_w[7:0] = value;
               2'd2: size_h = {value, 8'h00};
               default: size_h[7:0] = value;
            endcase
            if (size_index == 2'd3)
               phase = PHASE_SKIP;
            size_index++;
         end
         PHASE_CHAIN: begin
            more_flag = (value & DEP_MORE) != 0;
            if ((value & DEP_EXTENDED) != 0) begin
               diff_low = value[7:2];
               phase = PHASE_CHAIN_EXT;
            end else begin
               finish_dependency({8'h00, value[7:2]});
            end
         end
         PHASE_CHAIN_EXT: finish_dependency({value, diff_low});
         default: ;
      endcase

      // summary on the last byte
      if (fin) begin
         status = error_status;
         if (status == STATUS_OK && phase inside {PHASE_SPATIAL, PHASE_FRAME_LO,
             PHASE_FRAME_HI, PHASE_CHAIN, PHASE_CHAIN_EXT})
            status = STATUS_TRUNCATED;
         if (status == STATUS_OK && phase == PHASE_SKIP && dep_count == 0) begin
            w = size_w;
            h = size_h;
         end
         expected_results.push_back(make_result(KIND_SUMMARY, status, w, h, '0));
         clear_descriptor();
      end
   endfunction

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s expected %0d actual %0d", name, want, got);
         failures++;
      end
   endfunction

   // compare one result transfer with the oldest expectation
   function automatic void check_result();
      result_item_type want;
      if (expected_results.size() == 0) begin
         $error("result transfer with nothing expected, kind %0d status %0d",
                rsp_item_kind, rsp_status);
         failures++;
         return;
      end
      want = expected_results.pop_front();
      if (want.item_kind == KIND_SUMMARY)
         summary_count++;
      else
         dependency_count++;
      compare_field("item_kind", want.item_kind, rsp_item_kind);
      compare_field("status", want.status, rsp_status);
      compare_field("first_in_subframe", want.first_in_subframe, rsp_first_in_subframe);
      compare_field("last_in_subframe", want.last_in_subframe, rsp_last_in_subframe);
      compare_field("temporal_id", want.temporal_id, rsp_temporal_id);
      compare_field("spatial_mask", want.spatial_mask, rsp_spatial_mask);
      compare_field("frame_number", want.frame_number, rsp_frame_number);
      compare_field("frame_width", want.frame_width, rsp_frame_width);
      compare_field("frame_height", want.frame_height, rsp_frame_height);
      compare_field("id_difference", want.id_difference, rsp_id_difference);
      compare_field("dependency_total", want.dependency_total, rsp_dependency_total);
      compare_field("end_of_run", want.end_of_run, rsp_end_of_run);
   endfunction

   // result side: check each transfer, then stall for a drawn number of cycles
   always @(posedge clock) begin
      if (reset) begin
         stall_left = 0;
      end else if (rsp_valid && !rsp_stall) begin
         check_result();
         stall_left = $urandom_range(max_stall, 0);
      end else if (stall_left > 0) begin
         stall_left--;
      end
      rsp_stall <= (stall_left > 0);
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // one byte transfer after a drawn gap, predicted once accepted
   task automatic send_byte(input logic [7:0] value, input logic fin);
      int gap;
      gap = $urandom_range(max_gap, 0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload_byte <= value;
      req_final_byte <= fin;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      byte_count++;
      parse_byte(value, fin);
   endtask

   task automatic send_payload(input byte_list_type bytes);
      for (int i = 0; i < bytes.size(); i++)
         send_byte(bytes[i], i == bytes.size() - 1);
      payload_count++;
   endtask

   // mostly well-formed descriptors with random content, some noise and cuts
   task automatic send_random_payload();
      byte_list_type bytes;
      logic [7:0] head;
      logic [DIFF_W-1:0] diff;
      logic more;
      int pick;
      int deps;
      int sel;
      int count;
      int cut;
      pick = $urandom_range(99, 0);
      if (pick < 10) begin
         repeat ($urandom_range(6, 1)) bytes.push_back(8'($urandom_range(255, 0)));
      end else begin
         head = 8'($urandom_range(255, 0));
         if (pick >= 15)
            head |= FLAG_BEGIN;
         bytes.push_back(head);
         repeat (3) bytes.push_back(8'($urandom_range(255, 0)));
         if ((head & FLAG_CHAIN) != 0) begin
            deps = ($urandom_range(9, 0) == 0) ? MAX_DEPS + 1 : $urandom_range(MAX_DEPS, 1);
            for (int i = 0; i < deps; i++) begin
               sel = $urandom_range(19, 0);
               if (sel == 0)
                  diff = '0;
               else if (sel < 10)
                  diff = DIFF_W'($urandom_range(63, 1));
               else
                  diff = DIFF_W'($urandom_range(16383, 1));
               more = (i != deps - 1) || ($urandom_range(9, 0) == 0);
               if (diff < 64 && $urandom_range(3, 0) != 0) begin
                  bytes.push_back({diff[5:0], 1'b0, more});
               end else begin
                  bytes.push_back({diff[5:0], 1'b1, more});
                  bytes.push_back(diff[13:6]);
               end
            end
         end else begin
            count = $urandom_range(5, 0);
            if (count > 4)
               count = 4;
            repeat (count) bytes.push_back(8'($urandom_range(255, 0)));
         end
         if ($urandom_range(2, 0) == 0)
            repeat ($urandom_range(3, 1)) bytes.push_back(8'($urandom_range(255, 0)));
         if ($urandom_range(9, 0) == 0) begin
            cut = $urandom_range(bytes.size(), 1);
            while (bytes.size() > cut)
               void'(bytes.pop_back());
         end
      end
      send_payload(bytes);
   endtask

   function automatic int draw_idle_limit();
      int sel;
      sel = $urandom_range(3, 0);
      return (sel == 0) ? 0 : (sel == 1) ? 1 : 7;
   endfunction

   // header flags: begin clear alone, begin clear with extra bytes, short frame id
   task automatic test_header_flags();
      send_payload('{8'h47});
      send_payload('{8'h3F, 8'hC0});
      send_payload('{8'h80, 8'hA5, 8'h34});
   endtask

   // full resolution at its extremes
   task automatic test_resolution();
      send_payload('{8'hC7, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
      send_payload('{8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
   endtask

   // widest difference, full chain, then one too many with a zero difference
   task automatic test_dependency_limit();
      send_payload('{8'hCF, 8'h00, 8'h00, 8'h80, 8'hFF, 8'hFF, 8'hFD, 8'hFD, 8'hFD,
                     8'hFD, 8'hFD, 8'hFD, 8'hFD, 8'h01});
   endtask

   // zero difference with bytes after it, and an extension byte that never comes
   task automatic test_chain_errors();
      send_payload('{8'h88, 8'h01, 8'h02, 8'h03, 8'h00, 8'hAA});
      send_payload('{8'h88, 8'h00, 8'h00, 8'h00, 8'h06});
   endtask

   // random payloads up to the byte budget, idling mode redrawn every sixteen payloads
   task automatic test_random_payloads();
      int n;
      n = 0;
      while (byte_count < TOTAL_BYTES) begin
         if (n % 16 == 0) begin
            max_gap = draw_idle_limit();
            max_stall = draw_idle_limit();
         end
         send_random_payload();
         n++;
      end
   endtask

   // sender holds off until every expected result has come
   task automatic test_drain_pause();
      max_gap = 0;
      max_stall = 7;
      repeat (6) begin
         send_random_payload();
         req_valid <= 1'b0;
         @(posedge clock);
         while (expected_results.size() != 0)
            @(posedge clock);
      end
   endtask

   initial begin
      clear_descriptor();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_header_flags();
      test_resolution();
      test_dependency_limit();
      test_chain_errors();
      test_drain_pause();
      test_random_payloads();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      $display("sent %0d payloads in %0d byte transfers with random gaps and stalls",
               payload_count, byte_count);
      $display("compared %0d dependency results and %0d summaries, %0d mismatches",
               dependency_count, summary_count, failures);
      if (failures == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

/* files.f */
+incdir+src
src/fdp_pkg.sv
src/frame_descriptor_parser.sv
bench/testbench.sv
